[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the vertex transform RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clock, masked while reset is high
`define VT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising edge of clock, including reset cycles
`define VT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/vt_pkg.sv]
// ----------------------------------------------------------------------------
// vt_pkg
// Types and constants for the 4x4 Q16.16 vertex transform.
// ----------------------------------------------------------------------------
package vt_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic signed [47:0] term_type;
   typedef logic signed [49:0] sum_type;
   typedef logic signed [63:0] prod_type;

   typedef word_type vec_type [4];
   typedef word_type mat_type [4][4];
   typedef term_type terms_type [4][4];

   typedef struct packed {
      logic valid;
      logic point;
   } ctl_type;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_VECTOR = 2'd1;
   localparam logic [1:0] ACT_POINT  = 2'd2;

   localparam word_type Q_ONE    = 32'sh0001_0000;
   localparam word_type WORD_MAX = 32'sh7fff_ffff;
   localparam word_type WORD_MIN = 32'sh8000_0000;

endpackage

[src/vertex_transform_4x4.sv]
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// 4x4 Q16.16 matrix times vector. Load beats write one matrix entry; vector
// and point beats return the transformed vertex with a saturation flag.
//
//   channel  prefix  direction  beat
//   input    req_    in         load entry, transform vector or point
//   result   rsp_    out        x, y, z, w and saturated
//
// One beat per cycle sustained in both directions while rsp_stall is low.
// Input beat to rsp_valid passes the input register, the product register
// (16 multipliers) and the sum/saturate result register.
// Load and unused action beats retire at the input register with no result.
// rsp_stall backs up the pipeline; req_stall rises only when a transform
// beat in the input register cannot move on.
// Reset clears the pipeline and sets the matrix to identity.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_transform_4x4 (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [1:0]        req_entry_row,
   input  logic [1:0]        req_entry_col,
   input  vt_pkg::word_type  req_entry_value,
   input  vt_pkg::word_type  req_vec_x,
   input  vt_pkg::word_type  req_vec_y,
   input  vt_pkg::word_type  req_vec_z,
   input  vt_pkg::word_type  req_vec_w,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vt_pkg::word_type  rsp_out_x,
   output vt_pkg::word_type  rsp_out_y,
   output vt_pkg::word_type  rsp_out_z,
   output vt_pkg::word_type  rsp_out_w,
   output logic              rsp_saturated
);
   import vt_pkg::*;

   logic       s1_valid_ff;
   logic [1:0] s1_action_ff;
   logic [1:0] s1_row_ff;
   logic [1:0] s1_col_ff;
   word_type   s1_value_ff;
   vec_type    s1_vec_ff;

   logic       s1_xform;
   logic       mat_wr;
   mat_type    mat;
   ctl_type    mul_in_ctl;
   logic       mul_up_stall;
   ctl_type    sum_in_ctl;
   terms_type  sum_in_terms;
   logic       sum_up_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_action_ff <= req_action;
         s1_row_ff    <= req_entry_row;
         s1_col_ff    <= req_entry_col;
         s1_value_ff  <= req_entry_value;
         s1_vec_ff[0] <= req_vec_x;
         s1_vec_ff[1] <= req_vec_y;
         s1_vec_ff[2] <= req_vec_z;
         s1_vec_ff[3] <= req_vec_w;
      end
   end

   assign s1_xform = (s1_action_ff == ACT_VECTOR) || (s1_action_ff == ACT_POINT);
   assign mat_wr   = s1_valid_ff && (s1_action_ff == ACT_LOAD);

   // entry written as the load leaves the input register, in beat order
   assign req_stall = s1_valid_ff && s1_xform && mul_up_stall;

   assign mul_in_ctl.valid = s1_valid_ff && s1_xform;
   assign mul_in_ctl.point = (s1_action_ff == ACT_POINT);

   vt_matrix u_matrix (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mat_wr),
      .wr_row  (s1_row_ff),
      .wr_col  (s1_col_ff),
      .wr_data (s1_value_ff),
      .mat     (mat)
   );

   vt_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (mul_in_ctl),
      .in_vec    (s1_vec_ff),
      .in_mat    (mat),
      .up_stall  (mul_up_stall),
      .out_ctl   (sum_in_ctl),
      .out_terms (sum_in_terms),
      .dn_stall  (sum_up_stall)
   );

   vt_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (sum_in_ctl),
      .in_terms  (sum_in_terms),
      .up_stall  (sum_up_stall),
      .out_valid (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .out_w     (rsp_out_w),
      .out_sat   (rsp_saturated),
      .dn_stall  (rsp_stall)
   );

   `VT_ASSERT(a_stall_only_xform, req_stall |-> (s1_valid_ff && s1_xform), "input stalled without a transform beat")
   `VT_ASSERT(a_load_never_stalls, mat_wr |-> !req_stall, "matrix write while input register held")
   `VT_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> (!rsp_valid && !req_stall), "pipeline not empty after reset")

endmodule

[src/vt_matrix.sv]
// ----------------------------------------------------------------------------
// vt_matrix
// 4x4 Q16.16 matrix registers, reset to identity, one entry written per beat.
// ----------------------------------------------------------------------------
module vt_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [1:0]        wr_row,
   input  logic [1:0]        wr_col,
   input  vt_pkg::word_type  wr_data,
   output vt_pkg::mat_type   mat
);
   import vt_pkg::*;

   mat_type mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               mat_ff[r][c] <= (r == c) ? Q_ONE : '0;
            end
         end
      end else if (wr_en) begin
         mat_ff[wr_row][wr_col] <= wr_data;
      end
   end

   assign mat = mat_ff;

endmodule

[src/vt_mul_stage.sv]
// ----------------------------------------------------------------------------
// vt_mul_stage
// Sixteen 32x32 products, each taken >>> 16, registered. In point mode the
// fourth column passes the matrix entry itself as translation.
// ----------------------------------------------------------------------------
module vt_mul_stage (
   input  logic               clock,
   input  logic               reset,
   input  vt_pkg::ctl_type    in_ctl,
   input  vt_pkg::vec_type    in_vec,
   input  vt_pkg::mat_type    in_mat,
   output logic               up_stall,
   output vt_pkg::ctl_type    out_ctl,
   output vt_pkg::terms_type  out_terms,
   input  logic               dn_stall
);
   import vt_pkg::*;

   ctl_type   ctl_ff;
   terms_type terms_ff;
   terms_type terms_in;
   prod_type  prod [4][4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod[r][c] = in_mat[r][c] * in_vec[c];
            if (in_ctl.point && (c == 3)) begin
               terms_in[r][c] = term_type'(in_mat[r][c]);
            end else begin
               terms_in[r][c] = prod[r][c][63:16];
            end
         end
      end
   end

   assign up_stall = ctl_ff.valid && dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (!up_stall) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall) begin
         terms_ff <= terms_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_terms = terms_ff;

endmodule

[src/vt_sum_stage.sv]
// ----------------------------------------------------------------------------
// vt_sum_stage
// Row sums of four terms, saturation to 32 bits, result register.
// ----------------------------------------------------------------------------
module vt_sum_stage (
   input  logic               clock,
   input  logic               reset,
   input  vt_pkg::ctl_type    in_ctl,
   input  vt_pkg::terms_type  in_terms,
   output logic               up_stall,
   output logic               out_valid,
   output vt_pkg::word_type   out_x,
   output vt_pkg::word_type   out_y,
   output vt_pkg::word_type   out_z,
   output vt_pkg::word_type   out_w,
   output logic               out_sat,
   input  logic               dn_stall
);
   import vt_pkg::*;

   logic       valid_ff;
   word_type   res_ff [4];
   logic       sat_ff;
   sum_type    sum [4];
   word_type   res_in [4];
   logic [3:0] clip;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum[r] = sum_type'(in_terms[r][0]) + sum_type'(in_terms[r][1])
                + sum_type'(in_terms[r][2]) + sum_type'(in_terms[r][3]);
         if (sum[r] > sum_type'(WORD_MAX)) begin
            res_in[r] = WORD_MAX;
            clip[r]   = 1'b1;
         end else if (sum[r] < sum_type'(WORD_MIN)) begin
            res_in[r] = WORD_MIN;
            clip[r]   = 1'b1;
         end else begin
            res_in[r] = sum[r][31:0];
            clip[r]   = 1'b0;
         end
      end
      // point: w reported as zero, never clips
      if (in_ctl.point) begin
         res_in[3] = '0;
         clip[3]   = 1'b0;
      end
   end

   assign up_stall = valid_ff && dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall) begin
         res_ff <= res_in;
         sat_ff <= |clip;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = res_ff[0];
   assign out_y     = res_ff[1];
   assign out_z     = res_ff[2];
   assign out_w     = res_ff[3];
   assign out_sat   = sat_ff;

endmodule
